>>> src/spq_pkg.sv
package spq_pkg;

  // Default queue depth.
  localparam int unsigned CAPACITY_DEF = 16;

  // Fixed field widths.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PRI_W   = 8;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned NUM_W   = 5;

  typedef logic [OP_W-1:0] op_t;
  typedef logic [ST_W-1:0] status_t;

  // Operation codes.
  localparam op_t OP_PUSH   = 2'd0;
  localparam op_t OP_POP    = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  // Status codes.
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // One stored queue entry.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [PRI_W-1:0]          prio;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

>>> src/spq_if.sv
// Request channel.
interface spq_in_if;
  import spq_pkg::*;

  logic                      valid;
  logic                      ready;
  op_t                       operation;
  logic signed [VALUE_W-1:0] item_value;
  logic [PRI_W-1:0]          item_priority;

  modport source (output valid, output operation, output item_value,
                  output item_priority, input ready);
  modport sink   (input valid, input operation, input item_value,
                  input item_priority, output ready);
endinterface

// Result channel.
interface spq_out_if;
  import spq_pkg::*;

  logic                      valid;
  logic                      ready;
  status_t                   status;
  logic signed [VALUE_W-1:0] popped_value;
  logic [NUM_W-1:0]          entries_after;
  logic [NUM_W-1:0]          removed_number;

  modport source (output valid, output status, output popped_value,
                  output entries_after, output removed_number, input ready);
  modport sink   (input valid, input status, input popped_value,
                  input entries_after, input removed_number, output ready);
endinterface

>>> src/spq_ram.sv
module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/sorted_priority_queue.sv
// Channel   Port     Direction  Contents
// request   in_req   in         operation, item_value, item_priority
// result    out_rsp  out        status, popped_value, entries_after, removed_number
//
// A push moves back the entries that it passes, then writes the new entry; a pop or
// remove scans every entry; a rejected push, an empty pop or remove and an unused
// code go straight to the result. The entry RAM moves one entry per cycle.
// Reset clears the state, the entry count and the result valid flag only.
// A request can be taken in the cycle after the previous result is loaded, even while
// that result waits; the final step then holds until the output register is free.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_req,
  spq_out_if.source out_rsp
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PSH  = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [IW-1:0]             rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]             wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]             removed_r, removed_nxt;
  op_t                       op_r, op_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic [PRI_W-1:0]          pri_r, pri_nxt;
  status_t                   status_r, status_nxt;
  logic signed [VALUE_W-1:0] popped_r, popped_nxt;

  logic                      out_valid_r, out_valid_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic signed [VALUE_W-1:0] out_popped_r, out_popped_nxt;
  logic [NUM_W-1:0]          out_entries_r, out_entries_nxt;
  logic [NUM_W-1:0]          out_removed_r, out_removed_nxt;

  logic          ram_wr_en, ram_rd_en;
  logic [IW-1:0] ram_wr_addr, ram_rd_addr;
  entry_t        ram_wr_data, ram_rd_data;
  logic          hit;
  logic          last;

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_req.ready           = (state_r == S_IDLE);
  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_status_r;
  assign out_rsp.popped_value   = out_popped_r;
  assign out_rsp.entries_after  = out_entries_r;
  assign out_rsp.removed_number = out_removed_r;

  // During a scan, an entry is dropped when it is the front entry of a pop or
  // when its value matches that of a remove.
  assign hit  = (op_r == OP_POP) ? (rd_idx_r == '0) : (ram_rd_data.value == val_r);
  assign last = ((CW'(rd_idx_r) + CW'(1)) == count_r);

  // Sequencer: insertion walks down from the tail, compaction walks up from the head.
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    rd_idx_nxt      = rd_idx_r;
    wr_ptr_nxt      = wr_ptr_r;
    removed_nxt     = removed_r;
    op_nxt          = op_r;
    val_nxt         = val_r;
    pri_nxt         = pri_r;
    status_nxt      = status_r;
    popped_nxt      = popped_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    out_status_nxt  = out_status_r;
    out_popped_nxt  = out_popped_r;
    out_entries_nxt = out_entries_r;
    out_removed_nxt = out_removed_r;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = rd_idx_r;
    ram_wr_data     = '{value: val_r, prio: pri_r};
    ram_rd_en       = 1'b0;
    ram_rd_addr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          op_nxt      = in_req.operation;
          val_nxt     = in_req.item_value;
          pri_nxt     = in_req.item_priority;
          status_nxt  = ST_OK;
          popped_nxt  = '0;
          removed_nxt = '0;
          wr_ptr_nxt  = '0;
          rd_idx_nxt  = '0;
          unique case (in_req.operation)
            OP_PUSH: begin
              if (count_r == CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_OUT;
              end else if (count_r == '0) begin
                state_nxt = S_PUT;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = IW'(count_r - CW'(1));
                rd_idx_nxt  = IW'(count_r - CW'(1));
                state_nxt   = S_PSH;
              end
            end
            OP_POP, OP_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = (in_req.operation == OP_POP) ? ST_EMPTY : ST_OK;
                state_nxt  = S_OUT;
              end else begin
                ram_rd_en = 1'b1;
                state_nxt = S_CMP;
              end
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      S_PSH: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = rd_idx_r + IW'(1);
        if (pri_r < ram_rd_data.prio) begin
          // Move the entry back one place and keep walking toward the head.
          ram_wr_data = ram_rd_data;
          if (rd_idx_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = rd_idx_r - IW'(1);
            rd_idx_nxt  = rd_idx_r - IW'(1);
          end
        end else begin
          count_nxt = count_r + CW'(1);
          state_nxt = S_OUT;
        end
      end

      S_PUT: begin
        ram_wr_en = 1'b1;
        count_nxt = count_r + CW'(1);
        state_nxt = S_OUT;
      end

      S_CMP: begin
        if (hit) begin
          if (op_r == OP_REMOVE) begin
            removed_nxt = removed_r + CW'(1);
          end else begin
            popped_nxt = ram_rd_data.value;
          end
        end else begin
          // Keep the entry: write it at the compacted position.
          ram_wr_en   = 1'b1;
          ram_wr_addr = wr_ptr_r[IW-1:0];
          ram_wr_data = ram_rd_data;
          wr_ptr_nxt  = wr_ptr_r + CW'(1);
        end
        if (last) begin
          count_nxt = hit ? wr_ptr_r : (wr_ptr_r + CW'(1));
          state_nxt = S_OUT;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = rd_idx_r + IW'(1);
          rd_idx_nxt  = rd_idx_r + IW'(1);
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_popped_nxt  = popped_r;
          out_entries_nxt = NUM_W'(count_r);
          out_removed_nxt = NUM_W'(removed_r);
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    wr_ptr_r      <= wr_ptr_nxt;
    removed_r     <= removed_nxt;
    op_r          <= op_nxt;
    val_r         <= val_nxt;
    pri_r         <= pri_nxt;
    status_r      <= status_nxt;
    popped_r      <= popped_nxt;
    out_status_r  <= out_status_nxt;
    out_popped_r  <= out_popped_nxt;
    out_entries_r <= out_entries_nxt;
    out_removed_r <= out_removed_nxt;
  end

endmodule

>>> src/spq_checker.sv
module spq_checker
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input status_t                   status,
  input logic signed [VALUE_W-1:0] popped_value,
  input logic [NUM_W-1:0]          entries_after,
  input logic [NUM_W-1:0]          removed_number
);

  localparam logic [NUM_W-1:0] CAP_NUM = NUM_W'(CAPACITY);

  // A stalled result holds its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(entries_after) && $stable(status))
    else $error("stalled result changed");

  // A rejected push reports a full queue and nothing removed or popped.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_FULL |->
      entries_after == CAP_NUM && removed_number == '0 && popped_value == '0)
    else $error("full status with inconsistent fields");

  // A pop on an empty queue leaves it empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_EMPTY |-> entries_after == '0 && popped_value == '0)
    else $error("empty status with inconsistent fields");

  // Only a successful remove reports removed entries.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && removed_number != '0 |-> status == ST_OK && popped_value == '0)
    else $error("removed count on a non-remove result");

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY (CAPACITY)
) u_spq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .status         (out_rsp.status),
  .popped_value   (out_rsp.popped_value),
  .entries_after  (out_rsp.entries_after),
  .removed_number (out_rsp.removed_number)
);
